// File: design/wtd_pkg.sv
package wtd_pkg;

  // Command codes carried on the input stream.
  localparam logic [1:0] CMD_READY  = 2'd0;
  localparam logic [1:0] CMD_RESULT = 2'd1;
  localparam logic [1:0] CMD_TASK   = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_SENT_NEW   = 3'd0;
  localparam logic [2:0] KIND_SENT_WAIT  = 3'd1;
  localparam logic [2:0] KIND_RESENT     = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT    = 3'd3;
  localparam logic [2:0] KIND_QUEUED     = 3'd4;
  localparam logic [2:0] KIND_DROPPED    = 3'd5;
  localparam logic [2:0] KIND_READY_FULL = 3'd6;

  localparam int RUN_DEPTH = 16;
  localparam int RUN_IW    = $clog2(RUN_DEPTH);
  localparam int MAX_RES   = 16;
  localparam int RES_CW    = $clog2(MAX_RES + 1);

  localparam int DEF_IDLE_DEPTH  = 16;
  localparam int DEF_TASK_DEPTH  = 16;
  localparam int DEF_WORKER_BITS = 8;
  localparam int DEF_TAG_BITS    = 16;

  localparam logic [30:0] TIMEOUT_RESET = 31'd10000;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;

  // Per-entry commands for the running table.
  typedef struct packed {
    logic alloc;
    logic free;
    logic restamp;
    logic rework;
  } run_ctl_t;

endpackage

// File: design/worker_task_dispatcher.sv
// Worker/task dispatcher.
// Input stream (in_*): one transfer carries a command: worker ready, worker
// result, new task or time tick, with a worker id and a task tag.
// Output stream (out_*): the results caused by one command, in order; tlast
// marks the final result of that command. A command may cause no result.
// Configuration (cfg_*): APB-style port with one register, timeout_ticks, at
// address 0; write it only while the block is idle.
// Timing: commands are handled one at a time by a sequencer. A ready or result
// event queues the worker, then dispatches waiting tasks to idle workers. A
// tick runs the timeout scan, which visits the sixteen running-table cells one
// per cycle unless an expired entry waits for the output. The final result is
// held back in a pending register until its tlast value is known.
// Idle workers and waiting tasks live in chains of cells that shift toward
// the head on every pop.
// Reset clears the queue counts, the running table and the clock; timeout
// returns to 10000. When the receiver stalls, the sequencer waits with its
// state frozen; nothing is lost and in_tready stays low until it finishes.
module worker_task_dispatcher import wtd_pkg::*; #(
  parameter int IDLE_DEPTH  = DEF_IDLE_DEPTH,
  parameter int TASK_DEPTH  = DEF_TASK_DEPTH,
  parameter int WORKER_BITS = DEF_WORKER_BITS,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: cmd[1:0], worker_id[9:2], task_tag[25:10], zero.
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata fields from bit 0: kind[2:0], worker_id_out[10:3],
  // task_tag_out[26:11], old_worker[34:27], untracked[35], zero.
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ICW = $clog2(IDLE_DEPTH + 1);
  localparam int TCW = $clog2(TASK_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_READY = 3'd2;
  localparam logic [2:0] ST_DISP  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  typedef struct packed {
    logic [2:0]             kind;
    logic [WORKER_BITS-1:0] worker;
    logic [TAG_BITS-1:0]    tag;
    logic [WORKER_BITS-1:0] old;
    logic                   untr;
  } res_t;

  // Configuration register. pready is tied high, so writes complete in the
  // access phase.
  logic [30:0] timeout_r;
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr && (cfg_paddr == REG_TIMEOUT)) begin
      timeout_r <= cfg_pwdata[30:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_TIMEOUT) ? {1'b0, timeout_r} : 32'd0;

  // Sequencer state and the latched command.
  logic [2:0]             st_r, st_nxt;
  logic [RES_CW-1:0]      n_r, n_nxt;
  logic [RUN_IW-1:0]      idx_r, idx_nxt;
  logic [31:0]            now_r, now_nxt;
  logic [1:0]             cmd_r;
  logic [WORKER_BITS-1:0] w_r;
  logic [TAG_BITS-1:0]    t_r;

  // Idle-worker and waiting-task chains.
  logic                   idle_push, idle_pop, idle_hit;
  logic [WORKER_BITS-1:0] idle_head;
  logic [ICW-1:0]         idle_cnt;
  logic                   task_push, task_pop;
  logic [TAG_BITS-1:0]    task_head;
  logic [TCW-1:0]         task_cnt;

  wtd_fifo #(.DEPTH(IDLE_DEPTH), .W(WORKER_BITS)) u_idle (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (idle_push),
    .pop      (idle_pop),
    .push_data(w_r),
    .key      (w_r),
    .head     (idle_head),
    .count    (idle_cnt),
    .hit      (idle_hit)
  );

  wtd_fifo #(.DEPTH(TASK_DEPTH), .W(TAG_BITS)) u_task (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (task_push),
    .pop      (task_pop),
    .push_data(t_r),
    .key      ({TAG_BITS{1'b0}}),
    .head     (task_head),
    .count    (task_cnt),
    .hit      ()
  );

  // Running table: one cell per entry.
  run_ctl_t               run_ctl    [RUN_DEPTH];
  logic                   run_valid  [RUN_DEPTH];
  logic [WORKER_BITS-1:0] run_worker [RUN_DEPTH];
  logic [TAG_BITS-1:0]    run_task   [RUN_DEPTH];
  logic [31:0]            run_start  [RUN_DEPTH];
  logic                   run_hit    [RUN_DEPTH];
  logic [TAG_BITS-1:0]    run_wr_task;

  for (genvar i = 0; i < RUN_DEPTH; i++) begin : g_run
    wtd_run_cell #(.WB(WORKER_BITS), .TB(TAG_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (run_ctl[i]),
      .wr_worker(idle_head),
      .wr_task  (run_wr_task),
      .stamp    (now_r),
      .key      (w_r),
      .valid    (run_valid[i]),
      .worker   (run_worker[i]),
      .tsk      (run_task[i]),
      .start    (run_start[i]),
      .hit      (run_hit[i])
    );
  end

  // Lowest free entry for a new dispatch and lowest entry of the reporting
  // worker for a result event.
  logic [RUN_IW-1:0] free_idx, own_idx;
  logic              free_found, own_found;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    own_idx    = '0;
    own_found  = 1'b0;
    for (int i = RUN_DEPTH - 1; i >= 0; i--) begin
      if (!run_valid[i]) begin
        free_idx   = RUN_IW'(i);
        free_found = 1'b1;
      end
      if (run_hit[i]) begin
        own_idx   = RUN_IW'(i);
        own_found = 1'b1;
      end
    end
  end

  // The entry under the timeout scan.
  wire [31:0] sel_age     = now_r - run_start[idx_r];
  wire        sel_expired = run_valid[idx_r] && (sel_age > {1'b0, timeout_r});

  // Output register plus one held-back result whose tlast is still open.
  res_t out_r, out_nxt, pend_r, pend_nxt, emit_res;
  logic out_v_r, out_v_nxt, out_last_r, out_last_nxt, pend_v_r, pend_v_nxt;
  logic emit, fin_move;

  wire out_free = !out_v_r || out_tready;
  wire can_emit = !pend_v_r || out_free;

  always_comb begin
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    now_nxt     = now_r;
    idle_push   = 1'b0;
    idle_pop    = 1'b0;
    task_push   = 1'b0;
    task_pop    = 1'b0;
    run_wr_task = t_r;
    emit        = 1'b0;
    emit_res    = '0;
    fin_move    = 1'b0;
    for (int i = 0; i < RUN_DEPTH; i++) begin
      run_ctl[i] = '0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_r)
          CMD_READY: begin
            st_nxt = ST_READY;
          end
          CMD_RESULT: begin
            if (own_found) begin
              run_ctl[own_idx].free = 1'b1;
            end
            st_nxt = ST_READY;
          end
          CMD_TASK: begin
            if (can_emit) begin
              emit         = 1'b1;
              emit_res.tag = t_r;
              if (idle_cnt != '0) begin
                idle_pop        = 1'b1;
                run_ctl[free_idx].alloc = free_found;
                emit_res.kind   = KIND_SENT_NEW;
                emit_res.worker = idle_head;
                emit_res.untr   = !free_found;
              end else if (task_cnt < TCW'(TASK_DEPTH)) begin
                task_push     = 1'b1;
                emit_res.kind = KIND_QUEUED;
              end else begin
                emit_res.kind = KIND_DROPPED;
              end
              st_nxt = ST_FIN;
            end
          end
          default: begin
            now_nxt = now_r + 32'd1;
            idx_nxt = '0;
            st_nxt  = ST_SCAN;
          end
        endcase
      end
      ST_READY: begin
        // A worker already waiting is not queued twice and reports nothing.
        if (idle_hit) begin
          st_nxt = ST_DISP;
        end else if (idle_cnt < ICW'(IDLE_DEPTH)) begin
          idle_push = 1'b1;
          st_nxt    = ST_DISP;
        end else if (can_emit) begin
          emit            = 1'b1;
          emit_res.kind   = KIND_READY_FULL;
          emit_res.worker = w_r;
          st_nxt          = ST_DISP;
        end
      end
      ST_DISP: begin
        if ((idle_cnt != '0) && (task_cnt != '0) && (n_r < RES_CW'(MAX_RES))) begin
          if (can_emit) begin
            idle_pop    = 1'b1;
            task_pop    = 1'b1;
            run_wr_task = task_head;
            run_ctl[free_idx].alloc = free_found;
            emit            = 1'b1;
            emit_res.kind   = KIND_SENT_WAIT;
            emit_res.worker = idle_head;
            emit_res.tag    = task_head;
            emit_res.untr   = !free_found;
          end
        end else begin
          st_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (!sel_expired || can_emit) begin
          if (sel_expired) begin
            emit                     = 1'b1;
            run_ctl[idx_r].restamp   = 1'b1;
            emit_res.tag             = run_task[idx_r];
            emit_res.old             = run_worker[idx_r];
            if (idle_cnt != '0) begin
              idle_pop               = 1'b1;
              run_ctl[idx_r].rework  = 1'b1;
              emit_res.kind          = KIND_RESENT;
              emit_res.worker        = idle_head;
            end else begin
              emit_res.kind          = KIND_TIMEOUT;
            end
          end
          if (idx_r == RUN_IW'(RUN_DEPTH - 1)) begin
            st_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + RUN_IW'(1);
          end
        end
      end
      ST_FIN: begin
        if (!pend_v_r) begin
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          fin_move = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (st_r == ST_IDLE) begin
      n_nxt = '0;
    end else begin
      n_nxt = n_r + RES_CW'(emit);
    end

    // A new result pushes the held one out with tlast low; at the end the
    // held one leaves with tlast high.
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_tready;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    if (emit) begin
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end else if (fin_move) begin
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      n_r      <= '0;
      idx_r    <= '0;
      now_r    <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      n_r      <= n_nxt;
      idx_r    <= idx_nxt;
      now_r    <= now_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    pend_r     <= pend_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tdata[1:0];
      w_r   <= WORKER_BITS'(in_tdata[9:2]);
      t_r   <= TAG_BITS'(in_tdata[25:10]);
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;

  logic [31:0] o_worker32, o_tag32, o_old32;
  assign o_worker32 = 32'(out_r.worker);
  assign o_tag32    = 32'(out_r.tag);
  assign o_old32    = 32'(out_r.old);
  assign out_tdata  = {4'd0, out_r.untr, o_old32[7:0], o_tag32[15:0],
                       o_worker32[7:0], out_r.kind};

  // Queue counts never pass their depths.
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    idle_cnt <= ICW'(IDLE_DEPTH))
    else $error("idle count beyond depth");

  a_task_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    task_cnt <= TCW'(TASK_DEPTH))
    else $error("task count beyond depth");

  // No held-back result survives the end of a command.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !pend_v_r)
    else $error("result left pending while idle");

  // A taken command blocks the input in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

endmodule

// File: design/wtd_fifo_cell.sv
module wtd_fifo_cell import wtd_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] next_data,
  input  logic [W-1:0] key,
  output logic [W-1:0] data,
  output logic         match
);

  logic [W-1:0] data_r;

  // A pop moves every entry one place toward the head.
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= next_data;
    end else if (load) begin
      data_r <= load_data;
    end
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

// File: design/wtd_fifo.sv
module wtd_fifo import wtd_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int W     = 8,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          pop,
  input  logic [W-1:0]  push_data,
  input  logic [W-1:0]  key,
  output logic [W-1:0]  head,
  output logic [CW-1:0] count,
  output logic          hit
);

  logic [CW-1:0]    count_r, count_nxt;
  logic [W-1:0]     cdata [DEPTH];
  logic [DEPTH-1:0] cmatch;
  logic [DEPTH-1:0] inuse;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] nb;
    if (i == DEPTH - 1) begin : g_end
      assign nb = cdata[i];
    end else begin : g_mid
      assign nb = cdata[i+1];
    end
    assign inuse[i] = (CW'(i) < count_r);
    wtd_fifo_cell #(.W(W)) u_cell (
      .clk      (clk),
      .shift    (pop),
      .load     (push && (count_r == CW'(i))),
      .load_data(push_data),
      .next_data(nb),
      .key      (key),
      .data     (cdata[i]),
      .match    (cmatch[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + CW'(1);
    end else if (pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = cdata[0];
  assign count = count_r;
  assign hit   = |(cmatch & inuse);

endmodule

// File: design/wtd_run_cell.sv
module wtd_run_cell import wtd_pkg::*; #(
  parameter int WB = 8,
  parameter int TB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  run_ctl_t      ctl,
  input  logic [WB-1:0] wr_worker,
  input  logic [TB-1:0] wr_task,
  input  logic [31:0]   stamp,
  input  logic [WB-1:0] key,
  output logic          valid,
  output logic [WB-1:0] worker,
  output logic [TB-1:0] tsk,
  output logic [31:0]   start,
  output logic          hit
);

  logic          valid_r;
  logic [WB-1:0] worker_r;
  logic [TB-1:0] task_r;
  logic [31:0]   start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.alloc) begin
      valid_r <= 1'b1;
    end else if (ctl.free) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.alloc || ctl.rework) begin
      worker_r <= wr_worker;
    end
    if (ctl.alloc) begin
      task_r <= wr_task;
    end
    if (ctl.alloc || ctl.restamp) begin
      start_r <= stamp;
    end
  end

  assign valid  = valid_r;
  assign worker = worker_r;
  assign tsk    = task_r;
  assign start  = start_r;
  assign hit    = valid_r && (worker_r == key);

endmodule
